/* sv/lattice_coeff_rounding_unit_assert.svh */
// assertion helpers for the rounding unit
`ifndef LATTICE_COEFF_ROUNDING_UNIT_ASSERT_SVH
`define LATTICE_COEFF_ROUNDING_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LCRU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcru assertion failed");

// next-cycle implication, checked out of reset
`define LCRU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcru assertion failed");

`endif

/* sv/lcru_pkg.sv */
package lcru_pkg;

    typedef enum logic [1:0] {
        OP_P2R     = 2'd0,
        OP_DECOMP  = 2'd1,
        OP_HINT    = 2'd2,
        OP_INVALID = 2'd3
    } t_req_op;

    localparam int unsigned DROPPED_BITS_DEF = 13;

    localparam int unsigned MODQ      = 8380417;
    localparam int unsigned HALF_Q    = (MODQ - 1) / 2;
    localparam int unsigned TWO_G2_32 = 2 * ((MODQ - 1) / 32);
    localparam int unsigned TWO_G2_88 = 2 * ((MODQ - 1) / 88);

    // reciprocal constants and rounding offsets for the high part estimate
    localparam int unsigned RECIP_32  = 1025;
    localparam int unsigned RECIP_88  = 11275;
    localparam int unsigned RND_32    = 1 << 21;
    localparam int unsigned RND_88    = 1 << 23;
    localparam int unsigned PRE_RND   = 127;

    localparam int unsigned TOP_32    = 15;
    localparam int unsigned TOP_88    = 43;

    localparam int unsigned COEFF_W = 23;
    localparam int unsigned HIGH_W  = 10;
    localparam int unsigned LOW_W   = 19;

endpackage

/* sv/lattice_coeff_rounding_unit.sv */
// an accepted input beat passes the stage registers s1, s2, s3 and s4 in order to its output beat
// throughput: one beat per cycle; stages s1..s4 advance together when s4 is empty or taken
// s2 holds the reciprocal multiply, s3 the high part times 2*gamma2, s4 the low part fixup
// reset: synchronous active low, clears all stage valids and gamma2_mode
module lattice_coeff_rounding_unit #(
    parameter int unsigned DROPPED_BITS = lcru_pkg::DROPPED_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input beat
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [1:0]                             i_req_type,
    input  logic [lcru_pkg::COEFF_W-1:0]           i_coeff,
    input  logic                                   i_hint,
    // configuration
    input  logic                                   i_cfg_we,
    input  logic                                   i_cfg_wdata,
    // output beat
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [lcru_pkg::HIGH_W-1:0]            o_high_part,
    output logic signed [lcru_pkg::LOW_W-1:0]      o_low_part,
    output logic                                   o_bad_input
);

    `include "lattice_coeff_rounding_unit_assert.svh"

    // power2round sum is wide enough for the coefficient plus rounding and a 10 bit quotient
    localparam int unsigned SUM_W =
        (DROPPED_BITS + lcru_pkg::HIGH_W > 24) ? DROPPED_BITS + lcru_pkg::HIGH_W : 24;
    localparam int unsigned P2_RND = (1 << (DROPPED_BITS - 1)) - 1;

    localparam int unsigned T_W    = 17;  // (a + 127) >> 7
    localparam int unsigned PROD_W = 32;
    localparam int unsigned HI_W   = 6;
    localparam int unsigned M_W    = 24;
    localparam int unsigned R_W    = 25;

    // global advance: the whole pipe moves when the output slot frees up
    logic w_adv;

    logic r_gamma2_mode;

    // stage 1
    logic                               r_v1;
    lcru_pkg::t_req_op                  r_op1;
    logic                               r_bad1;
    logic                               r_hint1;
    logic [lcru_pkg::COEFF_W-1:0]       r_a1;
    logic [T_W-1:0]                     r_t1;
    logic [lcru_pkg::HIGH_W-1:0]        r_p2hi1;
    logic [lcru_pkg::LOW_W-1:0]         r_p2lo1;

    // stage 2
    logic                               r_v2;
    lcru_pkg::t_req_op                  r_op2;
    logic                               r_bad2;
    logic                               r_hint2;
    logic [lcru_pkg::COEFF_W-1:0]       r_a2;
    logic [PROD_W-1:0]                  r_prod2;
    logic [lcru_pkg::HIGH_W-1:0]        r_p2hi2;
    logic [lcru_pkg::LOW_W-1:0]         r_p2lo2;

    // stage 3
    logic                               r_v3;
    lcru_pkg::t_req_op                  r_op3;
    logic                               r_bad3;
    logic                               r_hint3;
    logic [lcru_pkg::COEFF_W-1:0]       r_a3;
    logic [HI_W-1:0]                    r_hi3;
    logic [M_W-1:0]                     r_m3;
    logic [lcru_pkg::HIGH_W-1:0]        r_p2hi3;
    logic [lcru_pkg::LOW_W-1:0]         r_p2lo3;

    // stage 4 (output register)
    logic                               r_v4;
    lcru_pkg::t_req_op                  r_op4;
    logic [lcru_pkg::HIGH_W-1:0]        r_hi4;
    logic [lcru_pkg::LOW_W-1:0]         r_lo4;
    logic                               r_bad4;

    // next values
    lcru_pkg::t_req_op                  n_op1;
    logic                               n_bad1;
    logic [SUM_W-1:0]                   w_p2_sum;
    logic [T_W-1:0]                     n_t1;
    logic [lcru_pkg::HIGH_W-1:0]        n_p2hi1;
    logic [lcru_pkg::LOW_W-1:0]         n_p2lo1;
    logic [PROD_W-1:0]                  n_prod2;
    logic [HI_W-1:0]                    n_hi3;
    logic [M_W-1:0]                     n_m3;
    logic signed [R_W-1:0]              w_r0_raw;
    logic signed [R_W-1:0]              w_r0;
    logic                               w_wrap;
    logic                               w_pos;
    logic [HI_W-1:0]                    w_hint_hi;
    logic [lcru_pkg::HIGH_W-1:0]        n_hi4;
    logic [lcru_pkg::LOW_W-1:0]         n_lo4;

    assign w_adv   = !r_v4 || !i_stall;
    assign o_stall = !w_adv;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma2_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_gamma2_mode <= i_cfg_wdata;
        end
    end

    // s1: range check, power2round, pre-rounded coefficient for the divide estimate
    always_comb begin
        n_op1    = lcru_pkg::t_req_op'(i_req_type);
        n_bad1   = (n_op1 == lcru_pkg::OP_INVALID) ||
                   (i_coeff >= lcru_pkg::COEFF_W'(lcru_pkg::MODQ));
        w_p2_sum = SUM_W'(i_coeff) + SUM_W'(P2_RND);
        // high part wraps to 10 bits when the dropped width is small
        n_p2hi1  = w_p2_sum[DROPPED_BITS +: lcru_pkg::HIGH_W];
        // low part = (a + half - 1) mod 2^D - (half - 1)
        n_p2lo1  = lcru_pkg::LOW_W'(w_p2_sum[DROPPED_BITS-1:0]) - lcru_pkg::LOW_W'(P2_RND);
        n_t1     = T_W'((24'(i_coeff) + 24'(lcru_pkg::PRE_RND)) >> 7);
    end

    // s2: reciprocal multiply with rounding offset
    always_comb begin
        if (r_gamma2_mode) begin
            n_prod2 = PROD_W'(r_t1) * PROD_W'(lcru_pkg::RECIP_88) + PROD_W'(lcru_pkg::RND_88);
        end else begin
            n_prod2 = PROD_W'(r_t1) * PROD_W'(lcru_pkg::RECIP_32) + PROD_W'(lcru_pkg::RND_32);
        end
    end

    // s3: pick the high part, fold the wrap case, scale back by 2*gamma2
    always_comb begin
        if (r_gamma2_mode) begin
            n_hi3 = r_prod2[24 +: HI_W];
            if (n_hi3 > HI_W'(lcru_pkg::TOP_88)) begin
                n_hi3 = '0;
            end
            n_m3 = M_W'(n_hi3) * M_W'(lcru_pkg::TWO_G2_88);
        end else begin
            // mod 16 keeps only four bits
            n_hi3 = HI_W'(r_prod2[25:22]);
            n_m3  = M_W'(n_hi3) * M_W'(lcru_pkg::TWO_G2_32);
        end
    end

    // s4: low part with the centered fixup, hint step, result select
    always_comb begin
        w_r0_raw = $signed({2'b00, r_a3}) - $signed({1'b0, r_m3});
        w_wrap   = w_r0_raw > $signed(R_W'(lcru_pkg::HALF_Q));
        w_r0     = w_wrap ? (w_r0_raw - $signed(R_W'(lcru_pkg::MODQ))) : w_r0_raw;
        // after the fixup the low part is positive only when it is above zero and did not wrap
        w_pos    = (w_r0_raw > $signed(R_W'(0))) && !w_wrap;

        w_hint_hi = r_hi3;
        if (r_hint3) begin
            if (r_gamma2_mode) begin
                if (w_pos) begin
                    w_hint_hi = (r_hi3 == HI_W'(lcru_pkg::TOP_88)) ? '0 : r_hi3 + HI_W'(1);
                end else begin
                    w_hint_hi = (r_hi3 == '0) ? HI_W'(lcru_pkg::TOP_88) : r_hi3 - HI_W'(1);
                end
            end else begin
                if (w_pos) begin
                    w_hint_hi = (r_hi3 + HI_W'(1)) & HI_W'(lcru_pkg::TOP_32);
                end else begin
                    w_hint_hi = (r_hi3 - HI_W'(1)) & HI_W'(lcru_pkg::TOP_32);
                end
            end
        end

        n_hi4 = '0;
        n_lo4 = '0;
        if (!r_bad3) begin
            case (r_op3)
                lcru_pkg::OP_P2R: begin
                    n_hi4 = r_p2hi3;
                    n_lo4 = r_p2lo3;
                end
                lcru_pkg::OP_DECOMP: begin
                    n_hi4 = lcru_pkg::HIGH_W'(r_hi3);
                    n_lo4 = w_r0[lcru_pkg::LOW_W-1:0];
                end
                lcru_pkg::OP_HINT: begin
                    n_hi4 = lcru_pkg::HIGH_W'(w_hint_hi);
                end
                default: begin
                    n_hi4 = '0;
                    n_lo4 = '0;
                end
            endcase
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // stage payloads, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_op1   <= n_op1;
            r_bad1  <= n_bad1;
            r_hint1 <= i_hint;
            r_a1    <= i_coeff;
            r_t1    <= n_t1;
            r_p2hi1 <= n_p2hi1;
            r_p2lo1 <= n_p2lo1;

            r_op2   <= r_op1;
            r_bad2  <= r_bad1;
            r_hint2 <= r_hint1;
            r_a2    <= r_a1;
            r_prod2 <= n_prod2;
            r_p2hi2 <= r_p2hi1;
            r_p2lo2 <= r_p2lo1;

            r_op3   <= r_op2;
            r_bad3  <= r_bad2;
            r_hint3 <= r_hint2;
            r_a3    <= r_a2;
            r_hi3   <= n_hi3;
            r_m3    <= n_m3;
            r_p2hi3 <= r_p2hi2;
            r_p2lo3 <= r_p2lo2;

            r_op4   <= r_op3;
            r_hi4   <= n_hi4;
            r_lo4   <= n_lo4;
            r_bad4  <= r_bad3;
        end
    end

    assign o_valid     = r_v4;
    assign o_high_part = r_hi4;
    assign o_low_part  = $signed(r_lo4);
    assign o_bad_input = r_bad4;

    // rejected beats carry an all-zero payload
    `LCRU_ASSERT_IMP(a_bad_zero, i_clk, i_rst_n, r_v4 && r_bad4, (r_hi4 == '0) && (r_lo4 == '0))

    // a blocked output beat must push back on the input side
    `LCRU_ASSERT_IMP(a_backpressure, i_clk, i_rst_n, r_v4 && i_stall, o_stall)

    // gamma2 high parts stay within their modulus
    `LCRU_ASSERT_IMP(a_hi_range, i_clk, i_rst_n,
        r_v4 && !r_bad4 && (r_op4 != lcru_pkg::OP_P2R),
        r_gamma2_mode ? (r_hi4 <= lcru_pkg::HIGH_W'(lcru_pkg::TOP_88))
                      : (r_hi4 <= lcru_pkg::HIGH_W'(lcru_pkg::TOP_32)))

    // the hint step gives no low part
    `LCRU_ASSERT_IMP(a_hint_lo, i_clk, i_rst_n,
        r_v4 && (r_op4 == lcru_pkg::OP_HINT), r_lo4 == '0)

    // a stalled output slot keeps its valid
    `LCRU_ASSERT_NXT(a_hold, i_clk, i_rst_n, r_v4 && i_stall, r_v4)

endmodule
